@@ src/tcs_pkg.sv @@
// Shared types and constants of the track and cascade segmenter.
package tcs_pkg;

  localparam int CNT_W = 31;
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic [3:0] REQ_SOURCE  = 4'd0;
  localparam logic [3:0] REQ_RECOIL  = 4'd1;
  localparam logic [3:0] REQ_SCATTER = 4'd2;
  localparam logic [3:0] REQ_STOP    = 4'd3;
  localparam logic [3:0] REQ_EXIT    = 4'd4;
  localparam logic [3:0] REQ_REPLACE = 4'd5;
  localparam logic [3:0] REQ_OTHER   = 4'd6;
  localparam logic [3:0] REQ_FINAL   = 4'd7;
  localparam logic [3:0] REQ_DISCARD = 4'd8;

  localparam logic [1:0] KIND_VERTEX      = 2'd0;
  localparam logic [1:0] KIND_TRACK_END   = 2'd1;
  localparam logic [1:0] KIND_CASCADE_END = 2'd2;
  localparam logic [1:0] KIND_DROP        = 2'd3;

  localparam logic [1:0] REG_WRAP_X = 2'd0;
  localparam logic [1:0] REG_WRAP_Y = 2'd1;
  localparam logic [1:0] REG_WRAP_Z = 2'd2;

  typedef struct packed {
    logic [3:0]         req_type;
    logic               gap_before;
    logic [31:0]        ion_number;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        energy;
    logic [31:0]        time_value;
    logic [14:0]        recoil_number;
    logic [14:0]        atom_number;
  } tcs_in_t;

  typedef struct packed {
    logic [1:0]         out_kind;
    logic [31:0]        cascade_number;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        out_energy;
    logic [31:0]        out_time;
    logic [14:0]        out_recoil;
    logic [14:0]        out_atom;
    logic [30:0]        track_begin_index;
    logic [30:0]        count_value;
    logic               last;
  } tcs_out_t;

  typedef struct packed {
    logic [1:0]          cnt;
    tcs_out_t [2:0]      rec;
  } tcs_bundle_t;

  typedef enum logic [2:0] {
    ST_WAIT    = 3'b001,
    ST_TRACK   = 3'b010,
    ST_BETWEEN = 3'b100
  } tcs_state_t;

endpackage

@@ src/track_cascade_segmenter.sv @@
// Top level of the track and cascade segmenter with its configuration registers.
//
// Event items enter through a queue-style port: an item is taken at a clock edge
// with push high and full low. Result items leave the same way: while empty is
// low the oldest result sits on out_data, and pop taken with empty low removes it.
// Each item yields zero to three results; the last result of an item has last set.
// The wrap limits are written through the APB-style port at byte addresses
// 0, 4 and 8; the user must do so only while the block is idle, which the block
// does not enforce. Reads return the current limits. The first result of an
// item enters the bundle queue when the item is accepted and moves into the
// output register after earlier results, when it is empty or popped. The front
// end takes one item per cycle while full is low; the output sequencer sends one
// result per cycle while pop is high, so items with several results hold up the
// input once the two-entry bundle queue fills. When the receiver stalls, results
// wait in the output register and the queue, and full rises once two bundles are
// waiting. Synchronous reset empties the queue and the output, returns the state
// machine to waiting for an ion and sets all wrap limits to their largest value.
module track_cascade_segmenter #(
  parameter int COORD_BITS = 32,
  parameter int COUNT_BITS = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  tcs_pkg::tcs_in_t  in_data,
  output logic              empty,
  input  logic              pop,
  output tcs_pkg::tcs_out_t out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tcs_pkg::*;

  logic [30:0] wrap_x_r, wrap_y_r, wrap_z_r;
  logic cfg_wr;
  logic q_push, q_full, q_pop, q_empty;
  tcs_bundle_t q_wr_data, q_rd_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_x_r <= '1;
      wrap_y_r <= '1;
      wrap_z_r <= '1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WRAP_X: wrap_x_r <= pwdata[30:0];
        REG_WRAP_Y: wrap_y_r <= pwdata[30:0];
        REG_WRAP_Z: wrap_z_r <= pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WRAP_X: prdata = {1'b0, wrap_x_r};
      REG_WRAP_Y: prdata = {1'b0, wrap_y_r};
      REG_WRAP_Z: prdata = {1'b0, wrap_z_r};
      default:    prdata = '0;
    endcase
  end

  tcs_front #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .wrap_x  (wrap_x_r),
    .wrap_y  (wrap_y_r),
    .wrap_z  (wrap_z_r),
    .q_push  (q_push),
    .q_data  (q_wr_data),
    .q_full  (q_full)
  );

  tcs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .q_empty (q_empty)
  );

  tcs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_rd_data),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

@@ src/tcs_front.sv @@
// Front end: accepts items, runs the track state machine and builds result bundles.
module tcs_front #(
  parameter int COORD_BITS = 32,
  parameter int COUNT_BITS = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  tcs_pkg::tcs_in_t    in_data,
  input  logic [30:0]         wrap_x,
  input  logic [30:0]         wrap_y,
  input  logic [30:0]         wrap_z,
  output logic                q_push,
  output tcs_pkg::tcs_bundle_t q_data,
  input  logic                q_full
);
  import tcs_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int CW = (DW > 31) ? DW : 31;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  tcs_state_t state_r, state_nxt;
  logic [31:0] cid_r, cid_nxt;
  logic [COUNT_BITS-1:0] vc_r, vc_nxt, tf_r, tf_nxt;
  logic [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [31:0] pt_r, pt_nxt, du_r, du_nxt;

  logic [COORD_BITS-1:0] cx, cy, cz;
  logic signed [31:0] ox, oy, oz;
  logic accept;
  logic split;
  logic [1:0] n_c;
  tcs_out_t [2:0] rec_c;

  generate
    if (COORD_BITS <= 32) begin : g_narrow_in
      assign cx = in_data.pos_x[COORD_BITS-1:0];
      assign cy = in_data.pos_y[COORD_BITS-1:0];
      assign cz = in_data.pos_z[COORD_BITS-1:0];
    end else begin : g_wide_in
      assign cx = {{(COORD_BITS-32){1'b0}}, in_data.pos_x};
      assign cy = {{(COORD_BITS-32){1'b0}}, in_data.pos_y};
      assign cz = {{(COORD_BITS-32){1'b0}}, in_data.pos_z};
    end
    if (COORD_BITS >= 32) begin : g_wide_out
      assign ox = cx[31:0];
      assign oy = cy[31:0];
      assign oz = cz[31:0];
    end else begin : g_narrow_out
      assign ox = {{(32-COORD_BITS){cx[COORD_BITS-1]}}, cx};
      assign oy = {{(32-COORD_BITS){cy[COORD_BITS-1]}}, cy};
      assign oz = {{(32-COORD_BITS){cz[COORD_BITS-1]}}, cz};
    end
  endgenerate

  function automatic logic step_over(input logic [COORD_BITS-1:0] p,
                                     input logic [COORD_BITS-1:0] c,
                                     input logic [30:0] lim);
    logic [DW-1:0] d;
    logic [DW-1:0] m;
    d = {p[COORD_BITS-1], p} - {c[COORD_BITS-1], c};
    m = d[DW-1] ? (~d + 1'b1) : d;
    return CW'(m) > CW'(lim);
  endfunction

  function automatic tcs_out_t mk_rec(input logic [1:0] kind, input logic [31:0] cid,
                                      input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z, input logic [31:0] e,
                                      input logic [31:0] t, input logic [14:0] rc,
                                      input logic [14:0] at, input logic [30:0] beg,
                                      input logic [30:0] cnt);
    tcs_out_t r;
    r.out_kind = kind;
    r.cascade_number = cid;
    r.out_x = x;
    r.out_y = y;
    r.out_z = z;
    r.out_energy = e;
    r.out_time = t;
    r.out_recoil = rc;
    r.out_atom = at;
    r.track_begin_index = beg;
    r.count_value = cnt;
    r.last = 1'b0;
    return r;
  endfunction

  assign accept = push && !q_full;
  assign full = q_full;
  assign split = step_over(px_r, cx, wrap_x) || step_over(py_r, cy, wrap_y)
              || step_over(pz_r, cz, wrap_z);

  always_comb begin
    tcs_state_t st;
    logic [31:0] cid;
    logic [COUNT_BITS-1:0] vc, tf;
    logic [31:0] pt, du;
    logic [COORD_BITS-1:0] px, py, pz;
    logic [1:0] n;
    tcs_out_t [2:0] rec;
    logic f_end_a, f_close, f_drop, f_new, f_begt, f_addv, f_end_b;
    tcs_state_t st_fin;

    st = state_r;
    cid = cid_r;
    vc = vc_r;
    tf = tf_r;
    pt = pt_r;
    du = du_r;
    px = px_r;
    py = py_r;
    pz = pz_r;
    n = 2'd0;
    rec = '0;
    f_end_a = 1'b0;
    f_close = 1'b0;
    f_drop = 1'b0;
    f_new = 1'b0;
    f_begt = 1'b0;
    f_addv = 1'b0;
    f_end_b = 1'b0;

    if (in_data.gap_before && state_r != ST_WAIT) begin
      rec[n] = mk_rec(KIND_DROP, cid, '0, '0, '0, '0, '0, '0, '0, '0, '0);
      n = n + 2'd1;
      vc = '0;
      tf = '0;
      du = '0;
      st = ST_WAIT;
    end
    st_fin = st;

    case (in_data.req_type)
      REQ_FINAL: begin
        f_end_a = (st == ST_TRACK);
        f_close = (st != ST_WAIT);
        st_fin = ST_WAIT;
      end
      REQ_DISCARD: begin
        f_drop = (st != ST_WAIT);
        st_fin = ST_WAIT;
      end
      default: begin
        case (st)
          ST_WAIT: begin
            if (in_data.req_type == REQ_SOURCE) begin
              f_new = 1'b1;
              f_addv = 1'b1;
              st_fin = ST_TRACK;
            end
          end
          ST_TRACK: begin
            case (in_data.req_type)
              REQ_SOURCE: begin
                f_end_a = 1'b1;
                f_close = 1'b1;
                f_new = 1'b1;
                f_addv = 1'b1;
              end
              REQ_RECOIL: begin
                f_end_a = 1'b1;
                f_begt = 1'b1;
                f_addv = 1'b1;
              end
              REQ_SCATTER: begin
                f_addv = 1'b1;
              end
              REQ_STOP, REQ_EXIT, REQ_REPLACE: begin
                f_addv = 1'b1;
                f_end_b = 1'b1;
                st_fin = ST_BETWEEN;
              end
              default: begin
              end
            endcase
          end
          ST_BETWEEN: begin
            if (in_data.req_type == REQ_SOURCE) begin
              f_close = 1'b1;
              f_new = 1'b1;
              f_addv = 1'b1;
              st_fin = ST_TRACK;
            end else if (in_data.req_type == REQ_RECOIL) begin
              f_begt = 1'b1;
              f_addv = 1'b1;
              st_fin = ST_TRACK;
            end
          end
          default: begin
            st_fin = ST_WAIT;
          end
        endcase
      end
    endcase

    if (f_end_a && vc > tf) begin
      rec[n] = mk_rec(KIND_TRACK_END, cid, '0, '0, '0, '0, pt, '0, '0,
                      CNT_W'(tf), CNT_W'(vc - tf));
      n = n + 2'd1;
      if (pt > du) du = pt;
    end
    if (f_close) begin
      if (vc != '0) begin
        rec[n] = mk_rec(KIND_CASCADE_END, cid, '0, '0, '0, '0, du, '0, '0, '0, CNT_W'(vc));
        n = n + 2'd1;
      end
      vc = '0;
      tf = '0;
      du = '0;
    end
    if (f_drop) begin
      rec[n] = mk_rec(KIND_DROP, cid, '0, '0, '0, '0, '0, '0, '0, '0, '0);
      n = n + 2'd1;
      vc = '0;
      tf = '0;
      du = '0;
    end
    if (f_new) begin
      cid = in_data.ion_number;
      vc = '0;
      tf = '0;
      du = '0;
    end
    if (f_new || f_begt) tf = vc;
    if (f_addv) begin
      if (vc > tf && split) begin
        rec[n] = mk_rec(KIND_TRACK_END, cid, '0, '0, '0, '0, pt, '0, '0,
                        CNT_W'(tf), CNT_W'(vc - tf));
        n = n + 2'd1;
        if (pt > du) du = pt;
        tf = vc;
      end
      rec[n] = mk_rec(KIND_VERTEX, cid, ox, oy, oz, in_data.energy, in_data.time_value,
                      in_data.recoil_number, in_data.atom_number, '0, '0);
      n = n + 2'd1;
      px = cx;
      py = cy;
      pz = cz;
      pt = in_data.time_value;
      if (vc != CNT_MAX) vc = vc + 1'b1;
    end
    if (f_end_b && vc > tf) begin
      rec[n] = mk_rec(KIND_TRACK_END, cid, '0, '0, '0, '0, pt, '0, '0,
                      CNT_W'(tf), CNT_W'(vc - tf));
      n = n + 2'd1;
      if (pt > du) du = pt;
    end
    if (n != 2'd0) rec[n - 2'd1].last = 1'b1;

    state_nxt = st_fin;
    cid_nxt = cid;
    vc_nxt = vc;
    tf_nxt = tf;
    pt_nxt = pt;
    du_nxt = du;
    px_nxt = px;
    py_nxt = py;
    pz_nxt = pz;
    n_c = n;
    rec_c = rec;
  end

  assign q_push = accept && (n_c != 2'd0);
  assign q_data.cnt = n_c;
  assign q_data.rec = rec_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
      cid_r <= '0;
      vc_r <= '0;
      tf_r <= '0;
      pt_r <= '0;
      du_r <= '0;
      px_r <= '0;
      py_r <= '0;
      pz_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
      cid_r <= cid_nxt;
      vc_r <= vc_nxt;
      tf_r <= tf_nxt;
      pt_r <= pt_nxt;
      du_r <= du_nxt;
      px_r <= px_nxt;
      py_r <= py_nxt;
      pz_r <= pz_nxt;
    end
  end

endmodule

@@ src/tcs_queue.sv @@
// Short bundle queue between the front end and the output sequencer.
module tcs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  tcs_pkg::tcs_bundle_t wr_data,
  output logic                 q_full,
  input  logic                 rd_en,
  output tcs_pkg::tcs_bundle_t rd_data,
  output logic                 q_empty
);
  import tcs_pkg::*;

  localparam logic [Q_AW:0] FULL_CNT = (Q_AW + 1)'(Q_DEPTH);

  tcs_bundle_t mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0] cnt_r;
  logic do_wr, do_rd;

  assign q_full = (cnt_r == FULL_CNT);
  assign q_empty = (cnt_r == '0);
  assign do_wr = wr_en && !q_full;
  assign do_rd = rd_en && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ src/tcs_back.sv @@
// Back end: unpacks bundles into single result items behind an output register.
module tcs_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcs_pkg::tcs_bundle_t q_data,
  input  logic                 q_empty,
  output logic                 q_pop,
  output tcs_pkg::tcs_out_t    out_data,
  output logic                 empty,
  input  logic                 pop
);
  import tcs_pkg::*;

  tcs_out_t out_r;
  logic valid_r;
  logic [1:0] idx_r;
  logic load;
  logic at_end;

  assign load = !q_empty && (!valid_r || pop);
  assign at_end = (idx_r == q_data.cnt - 2'd1);
  assign q_pop = load && at_end;
  assign out_data = out_r;
  assign empty = !valid_r;

  always_ff @(posedge clk) begin
    if (load) out_r <= q_data.rec[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r <= at_end ? 2'd0 : idx_r + 2'd1;
      end else if (pop) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ sim/tb_track_cascade_segmenter.sv @@
// Self-checking testbench for the track and cascade segmenter, with its predictor.
`timescale 1ns / 1ps

module tb_track_cascade_segmenter;
  import tcs_pkg::*;

  localparam logic [3:0] REQ_UNUSED_TOP = 4'hF;
  localparam int STEP_SPAN = 12000;
  localparam int IDLE_LIMIT = 2000;

  class seg_scoreboard;
    tcs_out_t expected_q[$];
    tcs_out_t item_recs[$];
    int unsigned errors;
    logic [30:0] limit_x, limit_y, limit_z;
    tcs_state_t state;
    logic [31:0] cascade_id;
    logic [30:0] vtx_count, track_first;
    logic signed [31:0] last_x, last_y, last_z;
    logic [31:0] last_time, duration;

    function new();
      errors = 0;
      limit_x = '1;
      limit_y = '1;
      limit_z = '1;
      state = ST_WAIT;
      cascade_id = '0;
      vtx_count = '0;
      track_first = '0;
      duration = '0;
      last_x = '0;
      last_y = '0;
      last_z = '0;
      last_time = '0;
    endfunction

    function void set_limit(logic [1:0] idx, logic [30:0] val);
      case (idx)
        REG_WRAP_X: limit_x = val;
        REG_WRAP_Y: limit_y = val;
        REG_WRAP_Z: limit_z = val;
        default: ;
      endcase
    endfunction

    function void emit(logic [1:0] kind, logic signed [31:0] x, logic signed [31:0] y,
                       logic signed [31:0] z, logic [31:0] e, logic [31:0] t,
                       logic [14:0] rc, logic [14:0] at, logic [30:0] first_idx,
                       logic [30:0] cnt);
      tcs_out_t r;
      if (item_recs.size() >= 3) return;
      r.out_kind = kind;
      r.cascade_number = cascade_id;
      r.out_x = x;
      r.out_y = y;
      r.out_z = z;
      r.out_energy = e;
      r.out_time = t;
      r.out_recoil = rc;
      r.out_atom = at;
      r.track_begin_index = first_idx;
      r.count_value = cnt;
      r.last = 1'b0;
      item_recs.insert(item_recs.size(), r);
    endfunction

    function void clear_cascade();
      vtx_count = '0;
      track_first = '0;
      duration = '0;
    endfunction

    function void end_track();
      if (vtx_count > track_first) begin
        emit(KIND_TRACK_END, 0, 0, 0, 0, last_time, 0, 0, track_first,
             vtx_count - track_first);
        if (last_time > duration) duration = last_time;
      end
    endfunction

    function void close_cascade();
      if (vtx_count != 0) emit(KIND_CASCADE_END, 0, 0, 0, 0, duration, 0, 0, 0, vtx_count);
      clear_cascade();
    endfunction

    function void drop_cascade();
      emit(KIND_DROP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      clear_cascade();
      state = ST_WAIT;
    endfunction

    function bit axis_jump(logic signed [31:0] a, logic signed [31:0] b, logic [30:0] lim);
      logic [32:0] d;
      d = {a[31], a} - {b[31], b};
      if (d[32]) d = -d;
      return d > {2'b00, lim};
    endfunction

    function void add_vertex(tcs_in_t it);
      if (vtx_count > track_first) begin
        if (axis_jump(last_x, it.pos_x, limit_x) || axis_jump(last_y, it.pos_y, limit_y) ||
            axis_jump(last_z, it.pos_z, limit_z)) begin
          end_track();
          track_first = vtx_count;
        end
      end
      emit(KIND_VERTEX, it.pos_x, it.pos_y, it.pos_z, it.energy, it.time_value,
           it.recoil_number, it.atom_number, 0, 0);
      last_x = it.pos_x;
      last_y = it.pos_y;
      last_z = it.pos_z;
      last_time = it.time_value;
      if (vtx_count != '1) vtx_count++;
    endfunction

    function void begin_track(tcs_in_t it);
      track_first = vtx_count;
      add_vertex(it);
    endfunction

    function void begin_cascade(tcs_in_t it);
      cascade_id = it.ion_number;
      clear_cascade();
      begin_track(it);
      state = ST_TRACK;
    endfunction

    function void note_item(tcs_in_t it);
      item_recs.delete();
      if (it.gap_before && state != ST_WAIT) drop_cascade();
      if (it.req_type == REQ_FINAL) begin
        if (state == ST_TRACK) end_track();
        if (state != ST_WAIT) close_cascade();
        state = ST_WAIT;
      end else if (it.req_type == REQ_DISCARD) begin
        if (state != ST_WAIT) drop_cascade();
        state = ST_WAIT;
      end else if (state == ST_WAIT) begin
        if (it.req_type == REQ_SOURCE) begin_cascade(it);
      end else if (state == ST_TRACK) begin
        if (it.req_type == REQ_SOURCE) begin
          end_track();
          close_cascade();
          begin_cascade(it);
        end else if (it.req_type == REQ_RECOIL) begin
          end_track();
          begin_track(it);
        end else if (it.req_type == REQ_SCATTER) begin
          add_vertex(it);
        end else if (it.req_type >= REQ_STOP && it.req_type <= REQ_REPLACE) begin
          add_vertex(it);
          end_track();
          state = ST_BETWEEN;
        end
      end else begin
        if (it.req_type == REQ_SOURCE) begin
          close_cascade();
          begin_cascade(it);
        end else if (it.req_type == REQ_RECOIL) begin
          begin_track(it);
          state = ST_TRACK;
        end
      end
      if (item_recs.size() > 0) item_recs[item_recs.size() - 1].last = 1'b1;
      foreach (item_recs[i]) expected_q.insert(expected_q.size(), item_recs[i]);
    endfunction

    function void check_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected %h, got %h", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(tcs_out_t got);
      tcs_out_t e;
      if (expected_q.size() == 0) begin
        $error("result item with nothing expected: %h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      check_field("out_kind", e.out_kind, got.out_kind);
      check_field("cascade_number", e.cascade_number, got.cascade_number);
      check_field("out_x", e.out_x, got.out_x);
      check_field("out_y", e.out_y, got.out_y);
      check_field("out_z", e.out_z, got.out_z);
      check_field("out_energy", e.out_energy, got.out_energy);
      check_field("out_time", e.out_time, got.out_time);
      check_field("out_recoil", e.out_recoil, got.out_recoil);
      check_field("out_atom", e.out_atom, got.out_atom);
      check_field("track_begin_index", e.track_begin_index, got.track_begin_index);
      check_field("count_value", e.count_value, got.count_value);
      check_field("last", e.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  tcs_in_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  tcs_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  seg_scoreboard sb = new();

  logic signed [31:0] cur_x = '0, cur_y = '0, cur_z = '0;
  logic [31:0] cur_time = '0;
  int burst_left = 0;
  int random_count = 0;
  int rx_run = 0;
  int idle_cycles = 0;

  track_cascade_segmenter u_dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (rx_run == 0) begin
      pop = ($urandom_range(0, 3) != 0);
      rx_run = pop ? $urandom_range(1, 40) : $urandom_range(1, 12);
    end
    rx_run--;
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_track_cascade_segmenter: errors");
        $finish;
      end
    end
  end

  function automatic int jitter();
    return int'($urandom_range(0, 2 * STEP_SPAN)) - STEP_SPAN;
  endfunction

  function automatic tcs_in_t make_item(logic [3:0] req, logic gap);
    tcs_in_t it;
    if ($urandom_range(0, 19) == 0) begin
      cur_x = $urandom;
      cur_y = $urandom;
      cur_z = $urandom;
      cur_time = $urandom;
    end else begin
      cur_x = cur_x + jitter();
      cur_y = cur_y + jitter();
      cur_z = cur_z + jitter();
      cur_time = cur_time + $urandom_range(0, 4096);
    end
    it.req_type = req;
    it.gap_before = gap;
    it.ion_number = $urandom;
    it.pos_x = cur_x;
    it.pos_y = cur_y;
    it.pos_z = cur_z;
    it.energy = $urandom;
    it.time_value = cur_time;
    it.recoil_number = $urandom_range(0, 32767);
    it.atom_number = $urandom_range(0, 32767);
    return it;
  endfunction

  // Entered and left at a falling edge; push stays high between items of a burst.
  task automatic send_item(tcs_in_t it);
    if (burst_left == 0) begin
      push = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
    end
    push = 1'b1;
    in_data = it;
    do @(posedge clk); while (full);
    sb.note_item(it);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send(logic [3:0] req, logic gap);
    send_item(make_item(req, gap));
  endtask

  task automatic send_at(logic [3:0] req, logic signed [31:0] x, logic signed [31:0] y,
                         logic signed [31:0] z);
    tcs_in_t it;
    it = make_item(req, 1'b0);
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    cur_x = x;
    cur_y = y;
    cur_z = z;
    send_item(it);
  endtask

  task automatic send_counted(logic [3:0] req);
    send_item(make_item(req, $urandom_range(0, 29) == 0));
    random_count++;
  endtask

  task automatic drain();
    push = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [30:0] val);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = {1'b0, val};
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_limit(idx, val);
    @(negedge clk) begin
      pwrite = 1'b0;
      penable = 1'b0;
    end
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {1'b0, val}) begin
      $error("wrap limit readback: expected %h, got %h", {1'b0, val}, prdata);
      sb.errors++;
    end
    @(negedge clk) begin
      psel = 1'b0;
      penable = 1'b0;
    end
  endtask

  function automatic logic [30:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return 31'($urandom_range(1024, 16384));
    endcase
  endfunction

  task automatic random_cascade();
    int n_tracks;
    n_tracks = $urandom_range(1, 4);
    send_counted(REQ_SOURCE);
    for (int t = 0; t < n_tracks; t++) begin
      if (t > 0) send_counted(REQ_RECOIL);
      repeat ($urandom_range(0, 5)) send_counted(REQ_SCATTER);
      if ($urandom_range(0, 4) != 0) send_counted(4'($urandom_range(REQ_STOP, REQ_REPLACE)));
    end
    case ($urandom_range(0, 9))
      0: send_counted(REQ_DISCARD);
      1, 2: ;
      default: send_counted(REQ_FINAL);
    endcase
  endtask

  task automatic run_random(int n);
    random_count = 0;
    while (random_count < n) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6))
          send(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end else begin
        random_cascade();
      end
    end
  endtask

  task automatic directed_items();
    tcs_in_t it;
    send(REQ_SCATTER, 1'b0);
    send(REQ_STOP, 1'b0);
    send(REQ_FINAL, 1'b0);
    send(REQ_DISCARD, 1'b0);
    send(REQ_OTHER, 1'b1);
    it = make_item(REQ_SOURCE, 1'b0);
    it.ion_number = '1;
    it.pos_x = 32'sh8000_0000;
    it.pos_y = 32'sh8000_0000;
    it.pos_z = 32'sh8000_0000;
    it.energy = '1;
    it.time_value = '1;
    it.recoil_number = '1;
    it.atom_number = '1;
    send_item(it);
    send_at(REQ_SCATTER, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send(REQ_OTHER, 1'b0);
    send(REQ_UNUSED_TOP, 1'b0);
    send(REQ_RECOIL, 1'b0);
    send_at(REQ_STOP, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send(REQ_SCATTER, 1'b0);
    send(REQ_RECOIL, 1'b0);
    send(REQ_EXIT, 1'b0);
    send(REQ_RECOIL, 1'b0);
    send(REQ_REPLACE, 1'b0);
    it = '0;
    it.req_type = REQ_SOURCE;
    send_item(it);
    send(REQ_SOURCE, 1'b0);
    send(REQ_FINAL, 1'b0);
    send(REQ_SOURCE, 1'b0);
    send(REQ_SCATTER, 1'b1);
    send(REQ_SOURCE, 1'b1);
    send(REQ_SOURCE, 1'b1);
    send(REQ_DISCARD, 1'b0);
    send(REQ_SOURCE, 1'b0);
    send(REQ_STOP, 1'b0);
    send(REQ_FINAL, 1'b0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    directed_items();
    drain();

    write_limit(REG_WRAP_X, '0);
    write_limit(REG_WRAP_Y, '0);
    write_limit(REG_WRAP_Z, '0);
    send_at(REQ_SOURCE, 5, 5, 5);
    send_at(REQ_SCATTER, 5, 5, 5);
    send_at(REQ_SCATTER, 6, 5, 5);
    send_at(REQ_SCATTER, 6, 4, 5);
    send_at(REQ_STOP, 6, 4, 6);
    send(REQ_DISCARD, 1'b0);

    repeat (4) begin
      drain();
      write_limit(REG_WRAP_X, pick_limit());
      write_limit(REG_WRAP_Y, pick_limit());
      write_limit(REG_WRAP_Z, pick_limit());
      run_random(50);
    end

    drain();
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_track_cascade_segmenter: clean");
    end else begin
      $display("tb_track_cascade_segmenter: errors");
    end
    $finish;
  end

endmodule
